/* hw/rtl/command_frame_deframer_defines.svh */
// Assertion macros for the command frame deframer.
`ifndef COMMAND_FRAME_DEFRAMER_DEFINES_SVH
`define COMMAND_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, idle during reset.
`define CFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, sampled on i_clk, idle during reset.
`define CFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* hw/rtl/cfd_pkg.sv */
// Shared types and constants for the command frame deframer.
package cfd_pkg;

    localparam int LEN_W        = 20;
    localparam int BYTE_W       = 8;
    localparam int OPC_W        = 8;
    localparam int HDR_W        = 24;
    localparam int HCNT_W       = 2;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 3;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [3:0]        HDR_VERSION     = 4'd1;
    localparam logic [HCNT_W-1:0] HDR_LAST_GATHER = 2'd3;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 20'd65536;

    // Register word index (paddr[2]).
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;

    typedef enum logic [2:0] {
        EV_HDR_BYTE = 3'd0,
        EV_HDR_OK   = 3'd1,
        EV_PAYLOAD  = 3'd2,
        EV_HDR_BAD  = 3'd3,
        EV_IGNORED  = 3'd4
    } t_event;

    typedef struct packed {
        t_event             event_res;
        logic [OPC_W-1:0]   opcode;
        logic [LEN_W-1:0]   payload_len;
        logic [BYTE_W-1:0]  payload_byte;
        logic               frame_last;
        logic               zero_terminated;
    } t_result;

endpackage

/* hw/rtl/cfd_apb_regs.sv */
// APB register file holding the maximum payload length.
module cfd_apb_regs
    import cfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      o_max_len
);

    logic [LEN_W-1:0] r_max_len;
    logic [LEN_W-1:0] n_max_len;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == REG_MAX_PAYLOAD_LEN);

    always_comb begin
        n_max_len = r_max_len;
        if (wr_en) begin
            n_max_len = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else begin
            r_max_len <= n_max_len;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_PAYLOAD_LEN) begin
            prdata = {{(APB_DATA_W-LEN_W){1'b0}}, r_max_len};
        end
    end

    assign o_max_len = r_max_len;

endmodule

/* hw/rtl/cfd_parser.sv */
// Frame state and single-step header/payload decode.
module cfd_parser
    import cfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_abort,
    input  logic [LEN_W-1:0]  i_max_len,
    output t_result           o_res
);

    logic [HDR_W-1:0]  r_hdr,     n_hdr;
    logic [HCNT_W-1:0] r_hcnt,    n_hcnt;
    logic              r_in_pay,  n_in_pay;
    logic [LEN_W-1:0]  r_remain,  n_remain;
    logic [OPC_W-1:0]  r_opcode,  n_opcode;
    logic [LEN_W-1:0]  r_length,  n_length;
    logic              r_closed,  n_closed;

    logic [3:0]        dec_ver;
    logic [OPC_W-1:0]  dec_opcode;
    logic [LEN_W-1:0]  dec_length;
    logic [LEN_W-1:0]  remain_dec;

    assign dec_ver    = r_hdr[23:20];
    assign dec_opcode = r_hdr[19:12];
    assign dec_length = {r_hdr[11:0], i_byte};
    assign remain_dec = r_remain - 1'b1;

    always_comb begin
        n_hdr    = r_hdr;
        n_hcnt   = r_hcnt;
        n_in_pay = r_in_pay;
        n_remain = r_remain;
        n_opcode = r_opcode;
        n_length = r_length;
        n_closed = r_closed;
        o_res.event_res       = EV_IGNORED;
        o_res.payload_byte    = '0;
        o_res.frame_last      = 1'b0;
        o_res.zero_terminated = 1'b0;

        if (i_abort) begin
            n_hdr    = '0;
            n_hcnt   = '0;
            n_in_pay = 1'b0;
            n_remain = '0;
            n_opcode = '0;
            n_length = '0;
            n_closed = 1'b0;
        end else if (r_closed) begin
            o_res.event_res = EV_IGNORED;
        end else if (r_in_pay) begin
            o_res.event_res    = EV_PAYLOAD;
            o_res.payload_byte = i_byte;
            n_remain           = remain_dec;
            if (remain_dec == '0) begin
                n_in_pay              = 1'b0;
                o_res.frame_last      = 1'b1;
                o_res.zero_terminated = (i_byte == '0);
            end
        end else if (r_hcnt != HDR_LAST_GATHER) begin
            n_hdr           = {r_hdr[HDR_W-BYTE_W-1:0], i_byte};
            n_hcnt          = r_hcnt + 1'b1;
            o_res.event_res = EV_HDR_BYTE;
        end else begin
            n_opcode = dec_opcode;
            n_length = dec_length;
            n_hcnt   = '0;
            n_hdr    = '0;
            if ((dec_ver != HDR_VERSION) || (dec_length > i_max_len)) begin
                o_res.event_res = EV_HDR_BAD;
                n_closed        = 1'b1;
            end else begin
                o_res.event_res = EV_HDR_OK;
                if (dec_length == '0) begin
                    o_res.frame_last      = 1'b1;
                    o_res.zero_terminated = 1'b1;
                end else begin
                    n_in_pay = 1'b1;
                    n_remain = dec_length;
                end
            end
        end

        o_res.opcode      = n_opcode;
        o_res.payload_len = n_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr    <= '0;
            r_hcnt   <= '0;
            r_in_pay <= 1'b0;
            r_remain <= '0;
            r_opcode <= '0;
            r_length <= '0;
            r_closed <= 1'b0;
        end else if (i_step) begin
            r_hdr    <= n_hdr;
            r_hcnt   <= n_hcnt;
            r_in_pay <= n_in_pay;
            r_remain <= n_remain;
            r_opcode <= n_opcode;
            r_length <= n_length;
            r_closed <= n_closed;
        end
    end

endmodule

/* hw/rtl/cfd_out_reg.sv */
// Result register driving the master stream.
module cfd_out_reg
    import cfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_res,
    output logic                   o_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_res.event_res;
    assign m_axis_tlast  = r_res.frame_last;
    assign m_axis_tdata  = {3'b000, r_res.zero_terminated, r_res.payload_byte,
                            r_res.payload_len, r_res.opcode};

endmodule

/* hw/rtl/command_frame_deframer.sv */
// Top level of the command frame deframer: input stage, parser, result register.
// An accepted request passes through the input register, then the result register, to the master side.
// Throughput: one byte per cycle while the master side takes results; the parser's header/payload step sits
// between the input register and the result register.
// The input stage can still take one byte while a finished result waits to be taken.
// Reset (synchronous, i_rst_n low): clear frame state, empty both stages,
// set max_payload_len to 65536.
`include "command_frame_deframer_defines.svh"

module command_frame_deframer
    import cfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [0] abort
    // master stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] opcode, [27:8] payload_len, [35:28] payload_byte,
    // [36] zero_terminated, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [2:0] event_res
    output logic                   m_axis_tlast,   // frame_last
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_abort;
    logic              s_accept;
    logic              out_free;
    logic              step;
    logic [LEN_W-1:0]  max_len;
    t_result           step_res;
    logic              m_is_payload;
    logic              m_is_hdr_ok;
    logic [BYTE_W:0]   in_held;

    cfd_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    // Input stage: take a request whenever the held byte is empty or moves on.
    assign s_axis_tready = !r_in_valid || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    // Advance the held byte through the parser when the result register frees up.
    assign step          = r_in_valid && out_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_accept) begin
            n_in_valid = 1'b1;
        end else if (out_free) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte  <= s_axis_tdata[BYTE_W-1:0];
            r_in_abort <= s_axis_tuser[0];
        end
    end

    cfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_abort   (r_in_abort),
        .i_max_len (max_len),
        .o_res     (step_res)
    );

    cfd_out_reg u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (step),
        .i_res         (step_res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    assign m_is_payload = (m_axis_tuser == EV_PAYLOAD);
    assign m_is_hdr_ok  = (m_axis_tuser == EV_HDR_OK);
    assign in_held      = {r_in_abort, r_in_byte};

    // A frame only ends on a payload byte or on an accepted empty header.
    `CFD_ASSERT_IMPL(a_last_event, m_axis_tvalid && m_axis_tlast, m_is_payload || m_is_hdr_ok)
    // The zero-terminated flag never shows outside a frame end.
    `CFD_ASSERT_IMPL(a_zterm_last, m_axis_tvalid && m_axis_tdata[36], m_axis_tlast)
    // A held byte stays put while the result register is blocked.
    `CFD_ASSERT_NEXT(a_in_hold, r_in_valid && !out_free, r_in_valid && $stable(in_held))
    // Payload bytes pass through only on payload events.
    `CFD_ASSERT_IMPL(a_pbyte_zero, m_axis_tvalid && !m_is_payload, m_axis_tdata[35:28] == 8'd0)

endmodule
